// ===== rtl/rvce_pkg.sv =====
// rvce_pkg: shared types and RISC-V encoding constants for the RVC expander
// no dependencies
`default_nettype none

package rvce_pkg;

  typedef logic [15:0] cinstr_t;
  typedef logic [31:0] instr_t;
  typedef logic [4:0]  reg_t;
  typedef logic [11:0] imm12_t;

  // quadrant codes, bits 1:0 of the compressed word
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  // base opcodes
  localparam logic [6:0] OPC_LOAD    = 7'h03;
  localparam logic [6:0] OPC_LOAD_FP = 7'h07;
  localparam logic [6:0] OPC_OP_IMM  = 7'h13;
  localparam logic [6:0] OPC_OP_IMMW = 7'h1b;
  localparam logic [6:0] OPC_STORE   = 7'h23;
  localparam logic [6:0] OPC_STOREFP = 7'h27;
  localparam logic [6:0] OPC_OP      = 7'h33;
  localparam logic [6:0] OPC_LUI     = 7'h37;
  localparam logic [6:0] OPC_OPW     = 7'h3b;
  localparam logic [6:0] OPC_BRANCH  = 7'h63;
  localparam logic [6:0] OPC_JALR    = 7'h67;
  localparam logic [6:0] OPC_JAL     = 7'h6f;

  localparam instr_t EBREAK_INSTR = 32'h0010_0073;

  // funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_W    = 3'd2;
  localparam logic [2:0] F3_D    = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // funct7 codes
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_SUB  = 7'h20;

  // fixed registers
  localparam reg_t REG_ZERO = 5'd0;
  localparam reg_t REG_RA   = 5'd1;
  localparam reg_t REG_SP   = 5'd2;

endpackage

`default_nettype wire

// ===== rtl/rvce_decode.sv =====
// rvce_decode: combinational RV64C to 32-bit instruction expansion
// depends on rvce_pkg
`default_nettype none

module rvce_decode (
  input  rvce_pkg::cinstr_t x,
  output rvce_pkg::instr_t  y
);
  import rvce_pkg::*;

  function automatic instr_t fmt_i(logic [6:0] opc, reg_t rd, logic [2:0] f3, reg_t rs1,
                                   imm12_t imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic instr_t fmt_s(logic [6:0] opc, logic [2:0] f3, reg_t rs1, reg_t rs2,
                                   imm12_t imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], opc};
  endfunction

  function automatic instr_t fmt_r(logic [6:0] opc, reg_t rd, logic [2:0] f3, reg_t rs1,
                                   reg_t rs2, logic [6:0] f7);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  logic [2:0] f3;
  reg_t       rfull, r2, rp1, rp2;
  imm12_t     imm6, shamt, imm4spn, imm_lw, imm_ld, imm16sp, imm_ldsp, imm_lwsp;
  imm12_t     imm_swsp, imm_sdsp;
  logic       s;
  logic [1:0] grp, op2;

  // field extraction
  assign f3    = x[15:13];
  assign rfull = x[11:7];
  assign r2    = x[6:2];
  assign rp1   = {2'b01, x[9:7]};
  assign rp2   = {2'b01, x[4:2]};
  assign s     = x[12];
  assign grp   = x[11:10];
  assign op2   = x[6:5];

  // immediate layouts
  assign imm6     = {{7{s}}, x[6:2]};
  assign shamt    = {6'd0, s, x[6:2]};
  assign imm4spn  = {2'b00, x[10:7], x[12:11], x[5], x[6], 2'b00};
  assign imm_lw   = {5'd0, x[5], x[12:10], x[6], 2'b00};
  assign imm_ld   = {4'd0, x[6:5], x[12:10], 3'b000};
  assign imm16sp  = {{3{s}}, x[4:3], x[5], x[2], x[6], 4'd0};
  assign imm_ldsp = {3'd0, x[4:2], s, x[6:5], 3'b000};
  assign imm_lwsp = {4'd0, x[3:2], s, x[6:4], 2'b00};
  assign imm_swsp = {4'd0, x[8:7], x[12:9], 2'b00};
  assign imm_sdsp = {3'd0, x[9:7], x[12:10], 3'b000};

  // expansion by quadrant and funct3
  always_comb begin
    y = '0;
    case (x[1:0])
      QUAD_0: begin
        case (f3)
          3'd0: y = (imm4spn != '0) ? fmt_i(OPC_OP_IMM, rp2, F3_ADD, REG_SP, imm4spn) : '0;
          3'd1: y = fmt_i(OPC_LOAD_FP, rp2, F3_D, rp1, imm_ld);
          3'd2: y = fmt_i(OPC_LOAD, rp2, F3_W, rp1, imm_lw);
          3'd3: y = fmt_i(OPC_LOAD, rp2, F3_D, rp1, imm_ld);
          3'd5: y = fmt_s(OPC_STOREFP, F3_D, rp1, rp2, imm_ld);
          3'd6: y = fmt_s(OPC_STORE, F3_W, rp1, rp2, imm_lw);
          3'd7: y = fmt_s(OPC_STORE, F3_D, rp1, rp2, imm_ld);
          default: y = '0;
        endcase
      end
      QUAD_1: begin
        case (f3)
          3'd0: y = fmt_i(OPC_OP_IMM, rfull, F3_ADD, rfull, imm6);
          3'd1: y = (rfull != REG_ZERO) ? fmt_i(OPC_OP_IMMW, rfull, F3_ADD, rfull, imm6) : '0;
          3'd2: y = fmt_i(OPC_OP_IMM, rfull, F3_ADD, REG_ZERO, imm6);
          3'd3: begin
            if (rfull == REG_SP) begin
              y = (imm16sp != '0) ? fmt_i(OPC_OP_IMM, REG_SP, F3_ADD, REG_SP, imm16sp) : '0;
            end else begin
              y = ({s, x[6:2]} != 6'd0) ? {{14{s}}, s, x[6:2], rfull, OPC_LUI} : '0;
            end
          end
          3'd4: begin
            case (grp)
              2'd0: y = fmt_i(OPC_OP_IMM, rp1, F3_SR, rp1, shamt);
              2'd1: y = fmt_i(OPC_OP_IMM, rp1, F3_SR, rp1, shamt | 12'h400);
              2'd2: y = fmt_i(OPC_OP_IMM, rp1, F3_AND, rp1, imm6);
              default: begin
                if (s) begin
                  case (op2)
                    2'd0: y = fmt_r(OPC_OPW, rp1, F3_ADD, rp1, rp2, F7_SUB);
                    2'd1: y = fmt_r(OPC_OPW, rp1, F3_ADD, rp1, rp2, F7_BASE);
                    default: y = '0;
                  endcase
                end else begin
                  case (op2)
                    2'd0: y = fmt_r(OPC_OP, rp1, F3_ADD, rp1, rp2, F7_SUB);
                    2'd1: y = fmt_r(OPC_OP, rp1, F3_XOR, rp1, rp2, F7_BASE);
                    2'd2: y = fmt_r(OPC_OP, rp1, F3_OR, rp1, rp2, F7_BASE);
                    default: y = fmt_r(OPC_OP, rp1, F3_AND, rp1, rp2, F7_BASE);
                  endcase
                end
              end
            endcase
          end
          3'd5: begin
            // jal x0 with J-type immediate
            y = {s, x[8], x[10:9], x[6], x[7], x[2], x[11], x[5:3], s, {8{s}},
                 REG_ZERO, OPC_JAL};
          end
          default: begin
            // beqz / bnez with B-type immediate
            y = {s, s, s, s, x[6:5], x[2], REG_ZERO, rp1, 2'b00, f3[0],
                 x[11:10], x[4:3], s, OPC_BRANCH};
          end
        endcase
      end
      QUAD_2: begin
        case (f3)
          3'd0: y = fmt_i(OPC_OP_IMM, rfull, F3_SLL, rfull, shamt);
          3'd1: y = fmt_i(OPC_LOAD_FP, rfull, F3_D, REG_SP, imm_ldsp);
          3'd2: y = (rfull != REG_ZERO) ? fmt_i(OPC_LOAD, rfull, F3_W, REG_SP, imm_lwsp) : '0;
          3'd3: y = (rfull != REG_ZERO) ? fmt_i(OPC_LOAD, rfull, F3_D, REG_SP, imm_ldsp) : '0;
          3'd4: begin
            if (!s) begin
              if (r2 != REG_ZERO) begin
                y = fmt_r(OPC_OP, rfull, F3_ADD, REG_ZERO, r2, F7_BASE);
              end else begin
                y = (rfull != REG_ZERO) ?
                    fmt_i(OPC_JALR, REG_ZERO, F3_ADD, rfull, '0) : '0;
              end
            end else if (rfull == REG_ZERO && r2 == REG_ZERO) begin
              y = EBREAK_INSTR;
            end else if (r2 != REG_ZERO) begin
              y = fmt_r(OPC_OP, rfull, F3_ADD, rfull, r2, F7_BASE);
            end else begin
              y = fmt_i(OPC_JALR, REG_RA, F3_ADD, rfull, '0);
            end
          end
          3'd5: y = fmt_s(OPC_STOREFP, F3_D, REG_SP, r2, imm_sdsp);
          3'd6: y = fmt_s(OPC_STORE, F3_W, REG_SP, r2, imm_swsp);
          default: y = fmt_s(OPC_STORE, F3_D, REG_SP, r2, imm_sdsp);
        endcase
      end
      default: y = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/rvc_instruction_expander_top.sv =====
// rvc_instruction_expander_top: registered RV64C expander, input and result registers
// depends on rvce_pkg and rvce_decode
// an accepted item passes the input register, the decode logic and the result register before it strobes
// throughput: one item per cycle; busy never rises, set by the single decode stage
// the receiver cannot stall; results leave on out_strobe for one cycle
// reset (rst_n low, synchronous) clears the valid flags of both stages
`default_nettype none

module rvc_instruction_expander_top (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  rvce_pkg::cinstr_t in_compressed_instr,
  output logic              out_strobe,
  output rvce_pkg::instr_t  out_expanded_instr
);
  import rvce_pkg::*;

  cinstr_t in_r;
  logic    in_vld_r;
  instr_t  dec_y;
  instr_t  out_r;
  logic    out_vld_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_r <= in_compressed_instr;
    end
  end

  // expansion logic
  rvce_decode u_decode (
    .x (in_r),
    .y (dec_y)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_r <= dec_y;
    end
  end

  assign busy               = 1'b0;
  assign out_strobe         = out_vld_r;
  assign out_expanded_instr = out_r;

  // checks
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> in_vld_r)
    else $error("accepted item not captured");

  a_item_flows: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |=> out_strobe)
    else $error("captured item produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(rst_n)) |-> $past(in_vld_r))
    else $error("result without item");

  a_quad3_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && in_r[1:0] == 2'b11) |=> (out_expanded_instr == '0))
    else $error("quadrant three not zeroed");

  a_legal_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_expanded_instr != '0) |-> (out_expanded_instr[1:0] == 2'b11))
    else $error("expanded instruction not 32-bit form");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking bench for rvc_instruction_expander_top, RV64C word in, 32-bit word out
// depends on rvce_pkg and the expander RTL; predicts or pins every expansion and checks each strobe
module tb;
  import rvce_pkg::*;

  localparam int MAX_GAP        = 12;
  localparam int RANDOM_ITEMS   = 900;
  localparam int BURST_SPAN     = 75;
  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 1000;

  // compressed funct3, quadrant zero
  localparam logic [2:0] C0_ADDI4SPN = 3'd0;
  localparam logic [2:0] C0_FLD      = 3'd1;
  localparam logic [2:0] C0_LW       = 3'd2;
  localparam logic [2:0] C0_LD       = 3'd3;
  localparam logic [2:0] C0_FSD      = 3'd5;
  localparam logic [2:0] C0_SW       = 3'd6;
  localparam logic [2:0] C0_SD       = 3'd7;
  // compressed funct3, quadrant one
  localparam logic [2:0] C1_ADDI     = 3'd0;
  localparam logic [2:0] C1_ADDIW    = 3'd1;
  localparam logic [2:0] C1_LI       = 3'd2;
  localparam logic [2:0] C1_LUI      = 3'd3;
  localparam logic [2:0] C1_ALU      = 3'd4;
  localparam logic [2:0] C1_J        = 3'd5;
  localparam logic [2:0] C1_BNEZ     = 3'd7;
  // compressed funct3, quadrant two
  localparam logic [2:0] C2_SLLI     = 3'd0;
  localparam logic [2:0] C2_FLDSP    = 3'd1;
  localparam logic [2:0] C2_LWSP     = 3'd2;
  localparam logic [2:0] C2_LDSP     = 3'd3;
  localparam logic [2:0] C2_JR_MV    = 3'd4;
  localparam logic [2:0] C2_FSDSP    = 3'd5;
  localparam logic [2:0] C2_SWSP     = 3'd6;
  // quadrant one alu group and register op selectors
  localparam logic [1:0] ALU_SRLI    = 2'd0;
  localparam logic [1:0] ALU_SRAI    = 2'd1;
  localparam logic [1:0] ALU_ANDI    = 2'd2;
  localparam logic [1:0] ALU_SUB     = 2'd0;
  localparam logic [1:0] ALU_XOR     = 2'd1;
  localparam logic [1:0] ALU_OR      = 2'd2;
  localparam logic [1:0] ALU_SUBW    = 2'd0;
  localparam logic [1:0] ALU_ADDW    = 2'd1;
  // branch funct3
  localparam logic [2:0] F3_BEQ      = F3_ADD;
  localparam logic [2:0] F3_BNE      = F3_SLL;

  localparam instr_t ILLEGAL_INSTR = 32'd0;
  localparam logic   PINNED = 1'b1;
  localparam logic   FREE   = 1'b0;

  typedef struct packed {
    cinstr_t word;
    logic    pinned;
    instr_t  value;
  } vector_row_t;

  typedef struct packed {
    cinstr_t word;
    instr_t  value;
  } expansion_t;

  // directed vectors; value only meaningful on pinned rows
  localparam vector_row_t DIRECTED_ROWS [50] = '{
    {16'h0000, PINNED, ILLEGAL_INSTR},       // all-zero word
    {16'hFFFF, PINNED, ILLEGAL_INSTR},       // quadrant three
    {16'h8000, PINNED, ILLEGAL_INSTR},       // reserved quadrant zero slot
    {16'h001C, PINNED, ILLEGAL_INSTR},       // addi4spn zero immediate
    {16'h207D, PINNED, ILLEGAL_INSTR},       // addiw rd zero
    {16'h507E, PINNED, ILLEGAL_INSTR},       // lwsp rd zero
    {16'h707E, PINNED, ILLEGAL_INSTR},       // ldsp rd zero
    {16'h6101, PINNED, ILLEGAL_INSTR},       // addi16sp zero immediate
    {16'h6281, PINNED, ILLEGAL_INSTR},       // lui zero immediate
    {16'h8002, PINNED, ILLEGAL_INSTR},       // jr rs1 zero
    {16'h9C41, PINNED, ILLEGAL_INSTR},       // word-op selector two
    {16'h9C61, PINNED, ILLEGAL_INSTR},       // word-op selector three
    {16'h9002, PINNED, EBREAK_INSTR},
    {16'h0001, PINNED, {25'd0, OPC_OP_IMM}}, // nop
    {16'h1FFC, FREE, 32'd0},                 // addi4spn max
    {16'h3FFC, FREE, 32'd0},                 // fld
    {16'h4000, FREE, 32'd0},                 // lw min offset
    {16'h7FFC, FREE, 32'd0},                 // ld
    {16'hA000, FREE, 32'd0},                 // fsd
    {16'hDFFC, FREE, 32'd0},                 // sw
    {16'hFFFC, FREE, 32'd0},                 // sd
    {16'h0FFD, FREE, 32'd0},                 // addi x31 +31
    {16'h1001, FREE, 32'd0},                 // addi hint rd zero, -32
    {16'h3FFD, FREE, 32'd0},                 // addiw
    {16'h5001, FREE, 32'd0},                 // li hint rd zero
    {16'h7FFD, FREE, 32'd0},                 // lui negative
    {16'h717D, FREE, 32'd0},                 // addi16sp negative
    {16'h93FD, FREE, 32'd0},                 // srli shamt 63
    {16'h97FD, FREE, 32'd0},                 // srai
    {16'h987D, FREE, 32'd0},                 // andi
    {16'h8F9D, FREE, 32'd0},                 // sub
    {16'h8FBD, FREE, 32'd0},                 // xor
    {16'h8FDD, FREE, 32'd0},                 // or
    {16'h8FFD, FREE, 32'd0},                 // and
    {16'h9F9D, FREE, 32'd0},                 // subw
    {16'h9FBD, FREE, 32'd0},                 // addw
    {16'hBFFD, FREE, 32'd0},                 // j offset -2
    {16'hC001, FREE, 32'd0},                 // beqz zero offset
    {16'hFFFD, FREE, 32'd0},                 // bnez offset -2
    {16'h1FFE, FREE, 32'd0},                 // slli x31 63
    {16'h3FFE, FREE, 32'd0},                 // fldsp
    {16'h5FFE, FREE, 32'd0},                 // lwsp
    {16'h7FFE, FREE, 32'd0},                 // ldsp
    {16'h8F82, FREE, 32'd0},                 // jr
    {16'h8FFE, FREE, 32'd0},                 // mv
    {16'h9F82, FREE, 32'd0},                 // jalr
    {16'h9FFE, FREE, 32'd0},                 // add
    {16'hBFFE, FREE, 32'd0},                 // fsdsp
    {16'hDFFE, FREE, 32'd0},                 // swsp
    {16'hFFFE, FREE, 32'd0}                  // sdsp
  };

  logic    clk;
  logic    rst_n;
  logic    start;
  logic    busy;
  cinstr_t in_compressed_instr;
  logic    out_strobe;
  instr_t  out_expanded_instr;

  // pinned value travels with the word it belongs to
  logic    gold_pinned;
  instr_t  gold_value;

  expansion_t pending_expansions[$];
  expansion_t head;
  int         mismatch_count;
  int         idle_cycles;

  rvc_instruction_expander_top DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_compressed_instr (in_compressed_instr),
    .out_strobe          (out_strobe),
    .out_expanded_instr  (out_expanded_instr)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // base instruction formats
  function automatic instr_t enc_i(logic [6:0] opc, reg_t rd, logic [2:0] f3, reg_t rs1,
                                   imm12_t imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic instr_t enc_r(logic [6:0] opc, reg_t rd, logic [2:0] f3, reg_t rs1,
                                   reg_t rs2, logic [6:0] f7);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic instr_t enc_s(logic [6:0] opc, logic [2:0] f3, reg_t rs1, reg_t rs2,
                                   imm12_t imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], opc};
  endfunction

  // expected 32-bit form of one compressed word, zero when illegal or reserved
  function automatic instr_t expand_rvc(cinstr_t w);
    logic [2:0]  f3;
    reg_t        rf, r2, rp1, rp2;
    imm12_t      simm6, uimm, nzimm;
    logic [1:0]  grp, op2;
    logic [12:0] boff;
    logic [20:0] joff;
    instr_t      res;
    f3    = w[15:13];
    rf    = w[11:7];
    r2    = w[6:2];
    rp1   = {2'b01, w[9:7]};
    rp2   = {2'b01, w[4:2]};
    simm6 = {{7{w[12]}}, w[6:2]};
    grp   = w[11:10];
    op2   = w[6:5];
    res   = ILLEGAL_INSTR;
    case (w[1:0])
      QUAD_0: begin
        if (f3 == C0_LW || f3 == C0_SW) uimm = {5'd0, w[5], w[12:10], w[6], 2'b00};
        else uimm = {4'd0, w[6:5], w[12:10], 3'b000};
        case (f3)
          C0_ADDI4SPN: begin
            nzimm = {2'd0, w[10:7], w[12:11], w[5], w[6], 2'b00};
            if (nzimm != '0) res = enc_i(OPC_OP_IMM, rp2, F3_ADD, REG_SP, nzimm);
          end
          C0_FLD: res = enc_i(OPC_LOAD_FP, rp2, F3_D, rp1, uimm);
          C0_LW:  res = enc_i(OPC_LOAD, rp2, F3_W, rp1, uimm);
          C0_LD:  res = enc_i(OPC_LOAD, rp2, F3_D, rp1, uimm);
          C0_FSD: res = enc_s(OPC_STOREFP, F3_D, rp1, rp2, uimm);
          C0_SW:  res = enc_s(OPC_STORE, F3_W, rp1, rp2, uimm);
          C0_SD:  res = enc_s(OPC_STORE, F3_D, rp1, rp2, uimm);
          default: res = ILLEGAL_INSTR;
        endcase
      end
      QUAD_1: begin
        case (f3)
          C1_ADDI: res = enc_i(OPC_OP_IMM, rf, F3_ADD, rf, simm6);
          C1_ADDIW: begin
            if (rf != REG_ZERO) res = enc_i(OPC_OP_IMMW, rf, F3_ADD, rf, simm6);
          end
          C1_LI: res = enc_i(OPC_OP_IMM, rf, F3_ADD, REG_ZERO, simm6);
          C1_LUI: begin
            if (rf == REG_SP) begin
              nzimm = {{3{w[12]}}, w[4:3], w[5], w[2], w[6], 4'b0000};
              if (nzimm != '0) res = enc_i(OPC_OP_IMM, REG_SP, F3_ADD, REG_SP, nzimm);
            end else if (w[12] || w[6:2] != '0) begin
              res = {{15{w[12]}}, w[6:2], rf, OPC_LUI};
            end
          end
          C1_ALU: begin
            case (grp)
              ALU_SRLI, ALU_SRAI: begin
                res = enc_i(OPC_OP_IMM, rp1, F3_SR, rp1,
                            {1'b0, grp == ALU_SRAI, 4'd0, w[12], w[6:2]});
              end
              ALU_ANDI: res = enc_i(OPC_OP_IMM, rp1, F3_AND, rp1, simm6);
              default: begin
                // register ops; word forms when bit 12 is set
                if (w[12]) begin
                  if (op2 == ALU_SUBW) res = enc_r(OPC_OPW, rp1, F3_ADD, rp1, rp2, F7_SUB);
                  else if (op2 == ALU_ADDW) res = enc_r(OPC_OPW, rp1, F3_ADD, rp1, rp2, F7_BASE);
                end else begin
                  case (op2)
                    ALU_SUB: res = enc_r(OPC_OP, rp1, F3_ADD, rp1, rp2, F7_SUB);
                    ALU_XOR: res = enc_r(OPC_OP, rp1, F3_XOR, rp1, rp2, F7_BASE);
                    ALU_OR:  res = enc_r(OPC_OP, rp1, F3_OR, rp1, rp2, F7_BASE);
                    default: res = enc_r(OPC_OP, rp1, F3_AND, rp1, rp2, F7_BASE);
                  endcase
                end
              end
            endcase
          end
          C1_J: begin
            joff = {{9{w[12]}}, w[12], w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0};
            res  = {joff[20], joff[10:1], joff[11], joff[19:12], REG_ZERO, OPC_JAL};
          end
          default: begin
            // beqz / bnez against x0
            boff = {{4{w[12]}}, w[12], w[6:5], w[2], w[11:10], w[4:3], 1'b0};
            res  = {boff[12], boff[10:5], REG_ZERO, rp1, (f3 == C1_BNEZ) ? F3_BNE : F3_BEQ,
                    boff[4:1], boff[11], OPC_BRANCH};
          end
        endcase
      end
      QUAD_2: begin
        case (f3)
          C2_SLLI: res = enc_i(OPC_OP_IMM, rf, F3_SLL, rf, {6'd0, w[12], w[6:2]});
          C2_FLDSP, C2_LDSP: begin
            uimm = {3'd0, w[4:2], w[12], w[6:5], 3'b000};
            if (f3 == C2_FLDSP) res = enc_i(OPC_LOAD_FP, rf, F3_D, REG_SP, uimm);
            else if (rf != REG_ZERO) res = enc_i(OPC_LOAD, rf, F3_D, REG_SP, uimm);
          end
          C2_LWSP: begin
            uimm = {4'd0, w[3:2], w[12], w[6:4], 2'b00};
            if (rf != REG_ZERO) res = enc_i(OPC_LOAD, rf, F3_W, REG_SP, uimm);
          end
          C2_JR_MV: begin
            if (!w[12]) begin
              if (r2 != REG_ZERO) res = enc_r(OPC_OP, rf, F3_ADD, REG_ZERO, r2, F7_BASE);
              else if (rf != REG_ZERO) res = enc_i(OPC_JALR, REG_ZERO, F3_ADD, rf, '0);
            end else if (rf == REG_ZERO && r2 == REG_ZERO) begin
              res = EBREAK_INSTR;
            end else if (r2 != REG_ZERO) begin
              res = enc_r(OPC_OP, rf, F3_ADD, rf, r2, F7_BASE);
            end else begin
              res = enc_i(OPC_JALR, REG_RA, F3_ADD, rf, '0);
            end
          end
          C2_SWSP: begin
            uimm = {4'd0, w[8:7], w[12:9], 2'b00};
            res  = enc_s(OPC_STORE, F3_W, REG_SP, r2, uimm);
          end
          default: begin
            uimm = {3'd0, w[9:7], w[12:10], 3'b000};
            res  = enc_s((f3 == C2_FSDSP) ? OPC_STOREFP : OPC_STORE, F3_D, REG_SP, r2, uimm);
          end
        endcase
      end
      default: res = ILLEGAL_INSTR;
    endcase
    return res;
  endfunction

  // random word, biased toward quadrants 0-2 and zero fields
  function automatic cinstr_t draw_word();
    logic [1:0] quads [3];
    cinstr_t    w;
    quads = '{QUAD_0, QUAD_1, QUAD_2};
    w = cinstr_t'($urandom_range(0, 16'hFFFF));
    if ($urandom_range(0, 9) != 0) w[1:0] = quads[$urandom_range(0, 2)];
    if ($urandom_range(0, 4) == 0) w[11:7] = REG_ZERO;
    else if ($urandom_range(0, 7) == 0) w[11:7] = REG_SP;
    if ($urandom_range(0, 4) == 0) w[6:2] = REG_ZERO;
    if ($urandom_range(0, 5) == 0) w[12] = 1'b0;
    if ($urandom_range(0, 15) == 0) w[12:5] = '0;
    return w;
  endfunction

  // present one item after an idle gap and hold it until accepted
  task automatic issue_word(cinstr_t w, logic pinned, instr_t value, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start               <= 1'b1;
    in_compressed_instr <= w;
    gold_pinned         <= pinned;
    gold_value          <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold the sender off until every expansion has come back
  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_expansions.size() != 0) @(posedge clk);
  endtask

  // result check, then capture of the item accepted at this edge
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_expansions.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result: want none got %h", $time, out_expanded_instr);
      end else begin
        head = pending_expansions.pop_front();
        if (out_expanded_instr !== head.value) begin
          mismatch_count++;
          $display("%0t word %h: want %h got %h", $time, head.word, head.value,
                   out_expanded_instr);
        end
      end
    end
    if (rst_n && start && !busy) begin
      pending_expansions.push_back({in_compressed_instr,
                                    gold_pinned ? gold_value : expand_rvc(in_compressed_instr)});
    end
  end

  // watchdog on cycles where neither an item nor a result moves
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t timeout: nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus: reset, directed vectors, random words with bursts and gaps
  initial begin
    mismatch_count      = 0;
    idle_cycles         = 0;
    rst_n               = 1'b0;
    start               = 1'b0;
    in_compressed_instr = '0;
    gold_pinned         = 1'b0;
    gold_value          = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      issue_word(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].value,
                 $urandom_range(0, MAX_GAP));
    end
    wait_for_drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_for_drain();
      // alternate back-to-back stretches with gapped ones
      if ((n / BURST_SPAN) % 2 == 1) issue_word(draw_word(), FREE, '0, 0);
      else issue_word(draw_word(), FREE, '0, $urandom_range(0, MAX_GAP));
    end
    start <= 1'b0;

    while (pending_expansions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
